### sv/smax_pkg.sv
// smax_pkg: shared types and constants of the moving average crossover block
// beat structs for the request and response channels, csr indexes, relation codes
// no dependencies
`default_nettype none

package smax_pkg;

   localparam int PRICE_W = 32;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_WINDOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_WINDOW  = 1'b1;

   localparam logic [CFG_W-1:0] SHORT_WINDOW_RESET = 7'd20;
   localparam logic [CFG_W-1:0] LONG_WINDOW_RESET  = 7'd50;

   localparam int REL_W = 2;
   localparam logic [REL_W-1:0] REL_EQUAL = 2'd0;
   localparam logic [REL_W-1:0] REL_BELOW = 2'd1;
   localparam logic [REL_W-1:0] REL_ABOVE = 2'd2;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [TIME_W-1:0]  sample_time;
      logic               new_series;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] signal_time;
      logic              buy;
   } rsp_type;

   // control that follows an item from the sum stage to the compare stages
   typedef struct packed {
      logic              valid;
      logic              new_series;
      logic              check;      // both averages exist for this sample
      logic              signal_ok;  // they also existed for the previous one
      logic [TIME_W-1:0] sample_time;
   } stage_ctl_type;

endpackage

`default_nettype wire

### sv/smax_ram.sv
// smax_ram: generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module smax_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

### sv/smax_sums.sv
// smax_sums: price window and running sums over the short and long windows
// depends on smax_pkg and smax_ram
`default_nettype none

module smax_sums
   import smax_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     en,
   input  wire logic                                     clear,
   input  wire logic                                     in_valid,
   input  wire req_type                                  in_data,
   input  wire logic          [CFG_W-1:0]                short_win,
   input  wire logic          [CFG_W-1:0]                long_win,
   output stage_ctl_type                                 ctl,
   output logic [PRICE_W+$clog2(MAX_WINDOW)-1:0]         short_sum,
   output logic [PRICE_W+$clog2(MAX_WINDOW)-1:0]         long_sum
);

   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 2);
   localparam int SUM_W = PRICE_W + AW;
   localparam int PW    = (AW > CFG_W ? AW : CFG_W) + 1;
   localparam int CMP_W = (CNT_W > CFG_W ? CNT_W : CFG_W);

   function automatic logic [AW-1:0] step_back(input logic [AW-1:0] base,
                                                input logic [CFG_W-1:0] w);
      logic [PW-1:0] t;
      t = PW'(base) + PW'(MAX_WINDOW) - PW'(w);
      if (t >= PW'(MAX_WINDOW)) begin
         t = t - PW'(MAX_WINDOW);
      end
      return AW'(t);
   endfunction

   function automatic logic [AW-1:0] step_fwd(input logic [AW-1:0] base);
      logic [AW-1:0] r;
      r = base + AW'(1);
      if (base == AW'(MAX_WINDOW - 1)) begin
         r = '0;
      end
      return r;
   endfunction

   // front side: pointer as seen by the next accepted beat
   logic [AW-1:0] wp_front_ff, wp_front_in;
   logic [AW-1:0] base_wp;
   logic [AW-1:0] addr_short, addr_long;

   // item stage
   logic                  s1_valid_ff;
   req_type               s1_req_ff;
   logic [AW-1:0]         s1_wp_ff;
   logic                  byp_short_ff, byp_long_ff;
   logic [PRICE_W-1:0]    byp_data_ff;

   logic [PRICE_W-1:0]    rd_short, rd_long;
   logic                  s1_fire;

   // series state
   logic [CNT_W-1:0]      seen_ff, seen_in;
   logic [SUM_W-1:0]      short_sum_ff, short_sum_in;
   logic [SUM_W-1:0]      long_sum_ff, long_sum_in;
   stage_ctl_type         ctl_ff, ctl_in;

   logic [CNT_W-1:0]      seen_base;
   logic [SUM_W-1:0]      short_base, long_base;
   logic [PRICE_W-1:0]    old_short, old_long;
   logic [CMP_W-1:0]      seen_cmp, seen_next_cmp, need_cmp;
   logic [CFG_W-1:0]      need;

   assign s1_fire = s1_valid_ff && en;

   always_comb begin
      base_wp     = in_data.new_series ? '0 : wp_front_ff;
      addr_short  = step_back(base_wp, short_win);
      addr_long   = step_back(base_wp, long_win);
      wp_front_in = step_fwd(base_wp);
   end

   smax_ram #(
      .WIDTH (PRICE_W),
      .DEPTH (MAX_WINDOW)
   ) u_window (
      .clock     (clock),
      .wr_en     (s1_fire),
      .wr_addr   (s1_wp_ff),
      .wr_data   (s1_req_ff.price),
      .rd_en     (in_valid),
      .rd_addr_a (addr_short),
      .rd_addr_b (addr_long),
      .rd_data_a (rd_short),
      .rd_data_b (rd_long)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_front_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else if (clear) begin
         wp_front_ff <= '0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         if (in_valid) begin
            wp_front_ff <= wp_front_in;
         end
      end
   end

   // the beat in the item stage writes the entry the next beat may read
   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_req_ff    <= in_data;
         s1_wp_ff     <= base_wp;
         byp_short_ff <= s1_fire && (addr_short == s1_wp_ff);
         byp_long_ff  <= s1_fire && (addr_long == s1_wp_ff);
         byp_data_ff  <= s1_req_ff.price;
      end
   end

   always_comb begin
      seen_base  = s1_req_ff.new_series ? '0 : seen_ff;
      short_base = s1_req_ff.new_series ? '0 : short_sum_ff;
      long_base  = s1_req_ff.new_series ? '0 : long_sum_ff;
      old_short  = byp_short_ff ? byp_data_ff : rd_short;
      old_long   = byp_long_ff ? byp_data_ff : rd_long;
      seen_cmp   = CMP_W'(seen_base);

      short_sum_in = short_base;
      if (seen_cmp >= CMP_W'(short_win)) begin
         short_sum_in = short_sum_in - SUM_W'(old_short);
      end
      short_sum_in = short_sum_in + SUM_W'(s1_req_ff.price);

      long_sum_in = long_base;
      if (seen_cmp >= CMP_W'(long_win)) begin
         long_sum_in = long_sum_in - SUM_W'(old_long);
      end
      long_sum_in = long_sum_in + SUM_W'(s1_req_ff.price);

      seen_in = seen_base;
      if (seen_base != CNT_W'(MAX_WINDOW + 1)) begin
         seen_in = seen_base + CNT_W'(1);
      end

      need          = (short_win > long_win) ? short_win : long_win;
      need_cmp      = CMP_W'(need);
      seen_next_cmp = CMP_W'(seen_in);

      ctl_in.valid       = s1_valid_ff;
      ctl_in.new_series  = s1_req_ff.new_series;
      ctl_in.check       = seen_next_cmp >= need_cmp;
      ctl_in.signal_ok   = seen_next_cmp > need_cmp;
      ctl_in.sample_time = s1_req_ff.sample_time;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         short_sum_ff <= '0;
         long_sum_ff  <= '0;
         ctl_ff.valid <= 1'b0;
      end else if (clear) begin
         seen_ff      <= '0;
         short_sum_ff <= '0;
         long_sum_ff  <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
         if (s1_valid_ff) begin
            seen_ff      <= seen_in;
            short_sum_ff <= short_sum_in;
            long_sum_ff  <= long_sum_in;
         end
      end
   end

   assign ctl       = ctl_ff;
   assign short_sum = short_sum_ff;
   assign long_sum  = long_sum_ff;

endmodule

`default_nettype wire

### sv/smax_cross.sv
// smax_cross: cross-multiplied average compare, crossover detection, result register
// depends on smax_pkg
`default_nettype none

module smax_cross
   import smax_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 clear,
   input  wire stage_ctl_type                        ctl,
   input  wire logic [PRICE_W+$clog2(MAX_WINDOW)-1:0] short_sum,
   input  wire logic [PRICE_W+$clog2(MAX_WINDOW)-1:0] long_sum,
   input  wire logic [CFG_W-1:0]                     short_win,
   input  wire logic [CFG_W-1:0]                     long_win,
   output logic                                      rsp_valid,
   output rsp_type                                   rsp_data
);

   localparam int SUM_W  = PRICE_W + $clog2(MAX_WINDOW);
   localparam int PROD_W = SUM_W + CFG_W;

   stage_ctl_type     ctl2_ff;
   logic [PROD_W-1:0] lhs_ff, rhs_ff;
   logic [REL_W-1:0]  prev_rel_ff, prev_rel_in;
   logic [REL_W-1:0]  rel;
   logic              hit, buy;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff.valid <= 1'b0;
      end else if (en) begin
         ctl2_ff <= ctl;
      end
   end

   // short average vs long average without division
   always_ff @(posedge clock) begin
      if (en) begin
         lhs_ff <= PROD_W'(short_sum) * PROD_W'(long_win);
         rhs_ff <= PROD_W'(long_sum) * PROD_W'(short_win);
      end
   end

   always_comb begin
      rel = REL_EQUAL;
      if (lhs_ff < rhs_ff) begin
         rel = REL_BELOW;
      end else if (lhs_ff > rhs_ff) begin
         rel = REL_ABOVE;
      end

      hit = 1'b0;
      buy = 1'b0;
      if (ctl2_ff.check && ctl2_ff.signal_ok) begin
         if (prev_rel_ff == REL_BELOW && rel == REL_ABOVE) begin
            hit = 1'b1;
            buy = 1'b1;
         end else if (prev_rel_ff == REL_ABOVE && rel == REL_BELOW) begin
            hit = 1'b1;
         end
      end

      prev_rel_in = prev_rel_ff;
      if (ctl2_ff.check) begin
         prev_rel_in = rel;
      end else if (ctl2_ff.new_series) begin
         prev_rel_in = REL_EQUAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_rel_ff  <= REL_EQUAL;
         rsp_valid_ff <= 1'b0;
      end else if (clear) begin
         prev_rel_ff <= REL_EQUAL;
      end else if (en) begin
         rsp_valid_ff <= ctl2_ff.valid && hit;
         if (ctl2_ff.valid) begin
            prev_rel_ff <= prev_rel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.signal_time <= ctl2_ff.sample_time;
         rsp_data_ff.buy         <= buy;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### sv/sma_crossover_signal.sv
// sma_crossover_signal: simple moving average crossover signal block, 20/50 windows by default
// path: a request beat that marks a crossover passes the item stage, sum, compare and result registers to rsp
// throughput: one request beat per cycle; the pipeline holds only while rsp is stalled
// reset: windows return to 20 and 50, series state and all pipeline valids clear
// depends on smax_pkg, smax_sums, smax_cross
`default_nettype none

module sma_crossover_signal
   import smax_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int SUM_W = PRICE_W + $clog2(MAX_WINDOW);

   // zero acts as one, anything above the window depth as the depth
   function automatic logic [CFG_W-1:0] eff_window(input logic [CFG_W-1:0] w);
      logic [CFG_W-1:0] r;
      r = w;
      if (w == '0) begin
         r = CFG_W'(1);
      end else if (int'(w) > MAX_WINDOW) begin
         r = CFG_W'(MAX_WINDOW);
      end
      return r;
   endfunction

   logic [CFG_W-1:0] short_win_ff, long_win_ff;
   logic             en;
   logic             accept;
   stage_ctl_type    ctl;
   logic [SUM_W-1:0] short_sum, long_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_win_ff <= eff_window(SHORT_WINDOW_RESET);
         long_win_ff  <= eff_window(LONG_WINDOW_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SHORT_WINDOW: short_win_ff <= eff_window(csr_wdata);
            CSR_LONG_WINDOW:  long_win_ff  <= eff_window(csr_wdata);
            default: ;
         endcase
      end
   end

   // whole pipeline moves together whenever the result register can take a beat
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && en;

   smax_sums #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_sums (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .clear     (csr_write),
      .in_valid  (accept),
      .in_data   (req_data),
      .short_win (short_win_ff),
      .long_win  (long_win_ff),
      .ctl       (ctl),
      .short_sum (short_sum),
      .long_sum  (long_sum)
   );

   smax_cross #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .clear     (csr_write),
      .ctl       (ctl),
      .short_sum (short_sum),
      .long_sum  (long_sum),
      .short_win (short_win_ff),
      .long_win  (long_win_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
